FILE: hdl/kwlm_pkg.sv
// kwlm_pkg: shared constants for the keyword line matcher
// no dependencies; used by the channel interfaces and the top level
package kwlm_pkg;

  localparam int BYTE_W      = 8;
  localparam int OUT_LINE_W  = 32;
  localparam int KEY_BYTES   = 32;   // bytes held by the four keyword registers
  localparam int KEY_WORDS   = 4;
  localparam int PAT_LEN_W   = 6;
  localparam int CFG_ADDR_W  = 6;
  localparam int CFG_DATA_W  = 64;
  localparam int REG_IDX_W   = 3;

  localparam logic [BYTE_W-1:0] NEWLINE_BYTE = 8'h0A;

  // register map, 8-byte stride
  localparam logic [REG_IDX_W-1:0] REG_PAT_0_7   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_PAT_8_15  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_PAT_16_23 = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_PAT_24_31 = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_PAT_LEN   = 3'd4;

  localparam logic [PAT_LEN_W-1:0] PAT_LEN_RESET = 6'd1;

endpackage

FILE: hdl/kwlm_in_if.sv
// kwlm_in_if: valid/ready channel carrying one text byte per beat
// depends on kwlm_pkg
interface kwlm_in_if;
  import kwlm_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] text_byte;
  logic              end_of_content;

  modport source (output valid, output text_byte, output end_of_content, input ready);
  modport sink   (input valid, input text_byte, input end_of_content, output ready);
endinterface

FILE: hdl/kwlm_out_if.sv
// kwlm_out_if: valid/ready channel carrying one match or close result per beat
// depends on kwlm_pkg
interface kwlm_out_if;
  import kwlm_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  match_found;
  logic [OUT_LINE_W-1:0] start_line;
  logic                  content_closed;

  modport source (output valid, output match_found, output start_line,
                  output content_closed, input ready);
  modport sink   (input valid, input match_found, input start_line,
                  input content_closed, output ready);
endinterface

FILE: hdl/keyword_line_matcher_unit.sv
// Streaming keyword matcher: one text byte per beat in, one result beat out per match
// or per final byte. A byte passes the input register, then the result register, and
// waits in the input register while the result side stalls. Throughput: one byte per
// cycle while the result side keeps up; the window compare and line arithmetic sit in
// one stage.
// Reset: synchronous, active low; keyword registers return to zero with length one,
// window fill and line counter restart; a final byte restarts them too.
module keyword_line_matcher_unit #(
  parameter int MAX_PATTERN = 32,
  parameter int LINE_BITS   = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  kwlm_in_if.sink                           in_bus,
  kwlm_out_if.source                        out_bus,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [kwlm_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [kwlm_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [kwlm_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                              pready
);
  import kwlm_pkg::*;

  localparam int CNT_W = $clog2(MAX_PATTERN + 1);
  localparam int SW    = (LINE_BITS > OUT_LINE_W) ? LINE_BITS : OUT_LINE_W;
  localparam logic [LINE_BITS-1:0] LINE_MAX = '1;
  localparam logic [SW-1:0]        FIELD_MAX = SW'({OUT_LINE_W{1'b1}});

  // configuration registers
  logic [CFG_DATA_W-1:0] pat_word_r [KEY_WORDS];
  logic [PAT_LEN_W-1:0]  pat_len_r;
  logic                  wr_en;
  logic [REG_IDX_W-1:0]  reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[CFG_ADDR_W-1:CFG_ADDR_W-REG_IDX_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int w = 0; w < KEY_WORDS; w++) pat_word_r[w] <= '0;
      pat_len_r <= PAT_LEN_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_PAT_0_7:   pat_word_r[0] <= pwdata;
        REG_PAT_8_15:  pat_word_r[1] <= pwdata;
        REG_PAT_16_23: pat_word_r[2] <= pwdata;
        REG_PAT_24_31: pat_word_r[3] <= pwdata;
        REG_PAT_LEN:   pat_len_r     <= pwdata[PAT_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_PAT_0_7:   prdata = pat_word_r[0];
      REG_PAT_8_15:  prdata = pat_word_r[1];
      REG_PAT_16_23: prdata = pat_word_r[2];
      REG_PAT_24_31: prdata = pat_word_r[3];
      REG_PAT_LEN:   prdata = CFG_DATA_W'(pat_len_r);
      default:       prdata = '0;
    endcase
  end

  // keyword set-up, refreshed every cycle from the registers
  logic [BYTE_W-1:0] key_bytes [KEY_BYTES];
  logic [CNT_W-1:0]  len_nxt, len_r;
  logic [CNT_W-1:0]  nl_nxt, nl_r;
  logic [BYTE_W-1:0] akey_nxt [MAX_PATTERN];
  logic [BYTE_W-1:0] akey_r   [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] kmask_nxt, kmask_r;

  always_comb begin
    for (int j = 0; j < KEY_BYTES; j++)
      key_bytes[j] = pat_word_r[j / 8][(j % 8) * BYTE_W +: BYTE_W];
  end

  always_comb begin
    if (pat_len_r == '0)
      len_nxt = CNT_W'(1);
    else if (pat_len_r > PAT_LEN_W'(MAX_PATTERN))
      len_nxt = CNT_W'(MAX_PATTERN);
    else
      len_nxt = CNT_W'(pat_len_r);
  end

  // keyword reversed so that its last byte lines up with the newest window entry
  always_comb begin
    int t;
    t = 0;
    for (int k = 0; k < MAX_PATTERN; k++) begin
      t = int'(len_nxt) - 1 - k;
      kmask_nxt[k] = (k < int'(len_nxt));
      akey_nxt[k]  = kmask_nxt[k] ? key_bytes[t[4:0]] : '0;
    end
  end

  // newlines inside the keyword, last byte excluded
  always_comb begin
    nl_nxt = '0;
    for (int i = 0; i < KEY_BYTES; i++)
      if (key_bytes[i] == NEWLINE_BYTE && (i + 1) < int'(len_nxt))
        nl_nxt = nl_nxt + CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    len_r   <= len_nxt;
    nl_r    <= nl_nxt;
    kmask_r <= kmask_nxt;
    for (int k = 0; k < MAX_PATTERN; k++) akey_r[k] <= akey_nxt[k];
  end

  // input register
  logic              a_valid_r;
  logic [BYTE_W-1:0] a_byte_r;
  logic              a_last_r;
  logic              a_go;
  logic              in_fire;
  logic              out_valid_r;

  assign a_go         = a_valid_r && (!out_valid_r || out_bus.ready);
  assign in_bus.ready = !a_valid_r || a_go;
  assign in_fire      = in_bus.valid && in_bus.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_fire) begin
      a_valid_r <= 1'b1;
    end else if (a_go) begin
      a_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_byte_r <= in_bus.text_byte;
      a_last_r <= in_bus.end_of_content;
    end
  end

  // stream state
  logic [BYTE_W-1:0]    window_r   [MAX_PATTERN];
  logic [BYTE_W-1:0]    window_nxt [MAX_PATTERN];
  logic [CNT_W-1:0]     bytes_seen_r, seen_nxt;
  logic [LINE_BITS-1:0] current_line_r, line_nxt;
  logic                 hit;
  logic [LINE_BITS-1:0] start_full;
  logic [SW-1:0]        start_wide;
  logic [OUT_LINE_W-1:0] start_nxt;

  always_comb begin
    window_nxt[0] = a_byte_r;
    for (int k = 1; k < MAX_PATTERN; k++) window_nxt[k] = window_r[k-1];
  end

  assign seen_nxt = (bytes_seen_r < CNT_W'(MAX_PATTERN)) ? bytes_seen_r + CNT_W'(1)
                                                         : bytes_seen_r;

  always_comb begin
    hit = (seen_nxt >= len_r);
    for (int k = 0; k < MAX_PATTERN; k++)
      if (kmask_r[k] && akey_r[k] != window_nxt[k]) hit = 1'b0;
  end

  // start line: current line less keyword newlines, floored at one, kept once the counter saturates; zero without a hit
  always_comb begin
    if (current_line_r == LINE_MAX)
      start_full = LINE_MAX;
    else if (current_line_r > LINE_BITS'(nl_r))
      start_full = current_line_r - LINE_BITS'(nl_r);
    else
      start_full = LINE_BITS'(1);
    start_wide = SW'(start_full);
    if (!hit)
      start_nxt = '0;
    else if (start_wide > FIELD_MAX)
      start_nxt = '1;
    else
      start_nxt = start_wide[OUT_LINE_W-1:0];
  end

  assign line_nxt = (a_byte_r == NEWLINE_BYTE && current_line_r != LINE_MAX)
                    ? current_line_r + LINE_BITS'(1) : current_line_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_seen_r   <= '0;
      current_line_r <= LINE_BITS'(1);
    end else if (a_go) begin
      bytes_seen_r   <= a_last_r ? '0 : seen_nxt;
      current_line_r <= a_last_r ? LINE_BITS'(1) : line_nxt;
    end
  end

  // entries past the fill count are never compared, so no clearing on a final byte
  always_ff @(posedge clk) begin
    if (a_go) begin
      for (int k = 0; k < MAX_PATTERN; k++) window_r[k] <= window_nxt[k];
    end
  end

  // result register
  logic                  match_r;
  logic [OUT_LINE_W-1:0] start_line_r;
  logic                  closed_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (a_go) begin
      out_valid_r <= hit || a_last_r;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_go) begin
      match_r      <= hit;
      start_line_r <= start_nxt;
      closed_r     <= a_last_r;
    end
  end

  assign out_bus.valid          = out_valid_r;
  assign out_bus.match_found    = match_r;
  assign out_bus.start_line     = start_line_r;
  assign out_bus.content_closed = closed_r;

  // every result beat is a match or a close
  a_result_reason: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (match_r || closed_r))
    else $error("result beat with neither match nor close");

  a_no_match_zero_line: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !match_r) |-> (start_line_r == '0))
    else $error("close without match carries a line number");

  a_match_line_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && match_r) |-> (start_line_r != '0))
    else $error("match reported on line zero");

  a_close_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (a_go && a_last_r) |=> (bytes_seen_r == '0 && current_line_r == LINE_BITS'(1)))
    else $error("stream state not restarted after final byte");

endmodule

FILE: tb/kwlm_checker.sv
`timescale 1ns / 1ps
// kwlm_checker: watches the byte, result and register ports of the keyword line matcher,
// predicts every result beat and compares it field by field
// depends on kwlm_pkg, kwlm_in_if and kwlm_out_if
module kwlm_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  kwlm_in_if                              in_mon,
  kwlm_out_if                             out_mon,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic                            pready,
  input  logic [kwlm_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [kwlm_pkg::CFG_DATA_W-1:0] pwdata,
  output int                              fail_count,
  output int                              results_owed
);
  import kwlm_pkg::*;

  typedef struct packed {
    logic                  match_found;
    logic [OUT_LINE_W-1:0] start_line;
    logic                  content_closed;
  } line_result_t;

  logic [CFG_DATA_W-1:0] key_words [KEY_WORDS];
  logic [PAT_LEN_W-1:0]  key_len;
  logic [BYTE_W-1:0]     window [KEY_BYTES];
  int                    window_fill;
  logic [OUT_LINE_W-1:0] line_no;
  line_result_t          owed_lines [$];

  initial fail_count = 0;

  function automatic logic [BYTE_W-1:0] key_byte(input int j);
    return key_words[j / 8][(j % 8) * 8 +: 8];
  endfunction

  function automatic void clear_text();
    for (int i = 0; i < KEY_BYTES; i++) window[i] = '0;
    window_fill = 0;
    line_no = 1;
  endfunction

  // returns 1 when the byte gives a result beat
  function automatic bit predict_byte(input logic [BYTE_W-1:0] b, input logic last,
                                      output line_result_t r);
    int                    n;
    int                    nl;
    int                    i;
    bit                    hit;
    logic [OUT_LINE_W-1:0] start;
    n = (key_len == 0) ? 1 : (key_len > KEY_BYTES) ? KEY_BYTES : int'(key_len);
    for (i = KEY_BYTES - 1; i > 0; i--) window[i] = window[i-1];
    window[0] = b;
    if (window_fill < KEY_BYTES) window_fill++;
    hit = (window_fill >= n);
    for (i = 0; i < n; i++)
      if (key_byte(i) != window[n-1-i]) hit = 1'b0;
    start = '0;
    if (hit) begin
      if (line_no == '1) begin
        start = line_no;
      end else begin
        // the match starts back across any newlines inside the keyword
        nl = 0;
        for (i = 0; i + 1 < n; i++)
          if (key_byte(i) == NEWLINE_BYTE) nl++;
        start = (line_no > nl) ? line_no - nl : 1;
      end
    end
    if (b == NEWLINE_BYTE && line_no != '1) line_no++;
    r.match_found    = hit;
    r.start_line     = start;
    r.content_closed = last;
    if (last) clear_text();
    return hit || last;
  endfunction

  always @(posedge clk) begin
    line_result_t want;
    line_result_t got;
    logic [REG_IDX_W-1:0] idx;
    if (!rst_n) begin
      for (int w = 0; w < KEY_WORDS; w++) key_words[w] = '0;
      key_len = PAT_LEN_RESET;
      clear_text();
      owed_lines.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        got.match_found    = out_mon.match_found;
        got.start_line     = out_mon.start_line;
        got.content_closed = out_mon.content_closed;
        if (owed_lines.size() == 0) begin
          $error("result beat with nothing outstanding: match_found %0d start_line %0d",
                 got.match_found, got.start_line);
          fail_count++;
        end else begin
          want = owed_lines.pop_front();
          if (got.match_found !== want.match_found) begin
            $error("match_found: expected %0d, got %0d", want.match_found, got.match_found);
            fail_count++;
          end
          if (got.start_line !== want.start_line) begin
            $error("start_line: expected %0d, got %0d", want.start_line, got.start_line);
            fail_count++;
          end
          if (got.content_closed !== want.content_closed) begin
            $error("content_closed: expected %0d, got %0d",
                   want.content_closed, got.content_closed);
            fail_count++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        if (predict_byte(in_mon.text_byte, in_mon.end_of_content, want))
          owed_lines = {owed_lines, want};
      end
      if (psel && penable && pwrite && pready) begin
        idx = paddr[CFG_ADDR_W-1:3];
        if (idx < KEY_WORDS) key_words[idx] = pwdata;
        else if (idx == REG_PAT_LEN) key_len = pwdata[PAT_LEN_W-1:0];
      end
    end
    results_owed = owed_lines.size();
  end

endmodule

FILE: tb/tb_keyword_line_matcher_unit.sv
`timescale 1ns / 1ps
// tb_keyword_line_matcher_unit: drives text bytes and keyword registers into the matcher,
// stalls the result side at random and reports the verdict from kwlm_checker
// depends on kwlm_pkg, kwlm_in_if, kwlm_out_if, kwlm_checker and the block itself
module tb_keyword_line_matcher_unit;
  import kwlm_pkg::*;

  localparam int ITEMS_PER_PHASE = 62;
  localparam int RANDOM_PHASES   = 8;
  localparam int STALL_LIMIT     = 2000;
  localparam int DRAIN_CYCLES    = 8;
  localparam logic [BYTE_W-1:0] CH_A = 8'h61;
  localparam logic [BYTE_W-1:0] CH_B = 8'h62;

  logic                  clk;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;
  int                    fail_count;
  int                    results_owed;
  bit                    quiet;
  int                    stall_left;
  int                    idle_cycles;
  logic [BYTE_W-1:0]     keyword [KEY_BYTES];

  kwlm_in_if  in_bus ();
  kwlm_out_if out_bus ();

  keyword_line_matcher_unit uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  kwlm_checker chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_mon       (in_bus),
    .out_mon      (out_bus),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .pready       (pready),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .fail_count   (fail_count),
    .results_owed (results_owed)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // result side stalls in bursts, never in the quiet stretch at the end
  always @(negedge clk) begin
    if (quiet || !rst_n) begin
      out_bus.ready <= 1'b1;
    end else if (stall_left > 0) begin
      out_bus.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 9) == 0) begin
      out_bus.ready <= 1'b0;
      stall_left <= $urandom_range(0, 9);
    end else begin
      out_bus.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
        (psel && penable && pwrite && pready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic logic [BYTE_W-1:0] pick_text_byte();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return CH_A;
    if (r < 7) return CH_B;
    if (r < 9) return NEWLINE_BYTE;
    return BYTE_W'($urandom);
  endfunction

  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
    int gap;
    gap = (!quiet && $urandom_range(0, 5) == 0) ? $urandom_range(1, 10) : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_bus.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_bus.valid          <= 1'b1;
    in_bus.text_byte      <= b;
    in_bus.end_of_content <= last;
    do @(posedge clk); while (!in_bus.ready);
  endtask

  task automatic cfg_write(input logic [REG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // hold the sender until every owed result is out and the pipe has emptied
  task automatic wait_drained();
    @(negedge clk);
    in_bus.valid <= 1'b0;
    while (results_owed != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic send_stream(input int key_n);
    int sent;
    int kind;
    int n;
    int j;
    logic [BYTE_W-1:0] b;
    sent = 0;
    while (sent < ITEMS_PER_PHASE) begin
      kind = $urandom_range(0, 9);
      if (kind < 6) n = key_n;
      else if (kind < 7) n = $urandom_range(0, key_n - 1);
      else n = 0;
      for (j = 0; j < n; j++) begin
        send_byte(keyword[j], (kind < 6) && (j == n - 1) && ($urandom_range(0, 4) == 0));
        sent++;
      end
      if (kind >= 6) begin
        n = $urandom_range(1, 6);
        for (j = 0; j < n; j++) begin
          b = (kind == 9) ? BYTE_W'($urandom) : pick_text_byte();
          send_byte(b, $urandom_range(0, 24) == 0);
          sent++;
        end
      end
    end
  endtask

  initial begin
    int phase;
    int len_code;
    int key_n;
    int k;
    logic [CFG_DATA_W-1:0] word;
    int phase_len [7];
    phase_len = '{2, 32, 63, 5, 1, 33, 12};
    rst_n                 = 1'b0;
    psel                  = 1'b0;
    penable               = 1'b0;
    pwrite                = 1'b0;
    paddr                 = '0;
    pwdata                = '0;
    in_bus.valid          = 1'b0;
    in_bus.text_byte      = '0;
    in_bus.end_of_content = 1'b0;
    out_bus.ready         = 1'b0;
    quiet                 = 1'b0;
    stall_left            = 0;
    idle_cycles           = 0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // keyword after reset is one zero byte
    send_byte(8'h00, 1'b0);
    send_byte(NEWLINE_BYTE, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    wait_drained();

    // newline inside the keyword, overlapping hits, writes past the register map
    cfg_write(REG_PAT_0_7, 64'hFFFF_FFFF_FF61_0A61);
    cfg_write(REG_PAT_LEN, 64'd3);
    for (k = 1; k <= 3; k++) cfg_write(REG_IDX_W'(REG_PAT_LEN + k), '1);
    send_byte(CH_A, 1'b0);
    send_byte(NEWLINE_BYTE, 1'b0);
    send_byte(CH_A, 1'b0);
    send_byte(NEWLINE_BYTE, 1'b0);
    send_byte(CH_A, 1'b1);
    wait_drained();

    // zero length behaves as one
    cfg_write(REG_PAT_0_7, '1);
    cfg_write(REG_PAT_LEN, 64'd0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'hFF, 1'b1);
    wait_drained();

    // restarted window fill must not match zero keyword bytes early
    cfg_write(REG_PAT_0_7, 64'hFFFF_FFFF_FFFF_0000);
    cfg_write(REG_PAT_LEN, 64'd2);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b1);
    wait_drained();

    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      quiet    = (phase == RANDOM_PHASES - 1);
      len_code = (phase < 7) ? phase_len[phase] : $urandom_range(1, 40);
      key_n    = (len_code == 0) ? 1 : (len_code > KEY_BYTES) ? KEY_BYTES : len_code;
      for (k = 0; k < KEY_BYTES; k++)
        keyword[k] = (k < key_n) ? pick_text_byte() : BYTE_W'($urandom);
      for (k = 0; k < KEY_WORDS; k++) begin
        for (int j = 0; j < 8; j++) word[j*8 +: 8] = keyword[k*8 + j];
        cfg_write(REG_IDX_W'(REG_PAT_0_7 + k), word);
      end
      cfg_write(REG_PAT_LEN, CFG_DATA_W'(len_code));
      send_stream(key_n);
      wait_drained();
    end

    if (fail_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

FILE: keyword_line_matcher_unit.f
hdl/kwlm_pkg.sv
hdl/kwlm_in_if.sv
hdl/kwlm_out_if.sv
hdl/keyword_line_matcher_unit.sv
tb/kwlm_checker.sv
tb/tb_keyword_line_matcher_unit.sv
